// ===== hw/rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg: constants for the linear probing hash table
// command and status codes used by the top level, not by its parts
// ----------------------------------------------------------------------------
`default_nettype none
package lpht_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_INSERT_OVERWRITE = 2'd1;
  localparam logic [1:0] CMD_GET = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_EXISTED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam int unsigned HASH_MULT = 31;
endpackage
`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open addressing hash table with linear probing
// insert, overwrite, get and remove on keys of up to eight bytes
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata low bit up)                    accept
// s_axis   in   command[1:0] key_bytes[65:2] key_length[69:66] value_in[101:70]
//                                                            tvalid & tready
// m_axis   out  status[1:0] value_out[33:2]                  tvalid & tready
//
// one item at a time: hash over key bytes one byte per cycle, then a read
// state and a check state for every visited slot, then a write-back state
// and an output state that holds until the result is taken
// after reset the slot state ram is cleared, one slot a cycle, while no
// item is accepted
// the result waits in the output register; a stall holds it there
// ----------------------------------------------------------------------------
`default_nettype none
module linear_probe_hash_table #(
  parameter int CAPACITY = 256,
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_KEY_BYTES = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command, key_bytes, key_length, value_in
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, value_out
  output logic [39:0]       m_axis_tdata
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = 8 * MAX_KEY_BYTES;
  localparam int SLOT_W = KW + 4 + VALUE_WIDTH;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [1:0] cmd;
  logic [63:0] key;
  logic [3:0] len;
  logic [VALUE_WIDTH-1:0] val;
  logic [63:0] hash;
  logic [3:0] hidx;
  logic [AW-1:0] slot;
  logic [CW-1:0] visited;
  logic found, have_tomb;
  logic [AW-1:0] match_s, tomb_s, empty_s;
  logic have_empty;
  logic [VALUE_WIDTH-1:0] match_val;
  logic [1:0] status;
  logic [31:0] vout;

  // flags ram: bit1 valid, bit0 tombstone
  logic fl_we;
  logic [AW-1:0] fl_waddr, rd_addr;
  logic [1:0] fl_wdata, fl_rdata;
  logic sd_we;
  logic [AW-1:0] sd_waddr;
  logic [SLOT_W-1:0] sd_wdata, sd_rdata;

  lpht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_flags (
    .clk, .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(rd_addr), .rdata(fl_rdata)
  );
  lpht_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slots (
    .clk, .we(sd_we), .waddr(sd_waddr), .wdata(sd_wdata),
    .raddr(rd_addr), .rdata(sd_rdata)
  );

  // item fields, key clipped and masked
  logic [3:0] in_len;
  logic [63:0] in_key, in_mask;
  always_comb begin
    in_len = (s_axis_tdata[69:66] > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES)
                                                         : s_axis_tdata[69:66];
    in_mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < in_len) in_mask[8*i +: 8] = 8'hff;
    end
    in_key = s_axis_tdata[65:2] & in_mask;
  end

  logic [KW-1:0] s_key;
  logic [3:0] s_len;
  logic [VALUE_WIDTH-1:0] s_val;
  assign s_key = sd_rdata[SLOT_W-1 -: KW];
  assign s_len = sd_rdata[VALUE_WIDTH +: 4];
  assign s_val = sd_rdata[VALUE_WIDTH-1:0];
  logic s_valid, s_tomb, s_match;
  assign s_valid = fl_rdata[1];
  assign s_tomb = fl_rdata[0];
  assign s_match = s_valid && s_len == len && s_key == key[KW-1:0];

  logic [AW-1:0] slot_inc;
  assign slot_inc = (slot == AW'(CAPACITY - 1)) ? '0 : slot + 1'b1;
  assign rd_addr = slot;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {6'd0, vout, status};

  // write-back decisions
  logic ins, do_new, do_ovw, do_rm;
  logic [AW-1:0] new_s;
  assign ins = (cmd == lpht_pkg::CMD_INSERT) || (cmd == lpht_pkg::CMD_INSERT_OVERWRITE);
  assign do_new = ins && !found && (have_tomb || have_empty);
  assign do_ovw = found && cmd == lpht_pkg::CMD_INSERT_OVERWRITE;
  assign do_rm = found && cmd == lpht_pkg::CMD_REMOVE;
  assign new_s = have_tomb ? tomb_s : empty_s;

  always_comb begin
    fl_we = 1'b0;
    fl_waddr = slot;
    fl_wdata = 2'b00;
    sd_we = 1'b0;
    sd_waddr = new_s;
    sd_wdata = {key[KW-1:0], len, val};
    if (state == S_CLEAR) begin
      fl_we = 1'b1;
    end else if (state == S_DONE) begin
      if (do_new) begin
        fl_we = 1'b1;
        fl_waddr = new_s;
        fl_wdata = 2'b10;
        sd_we = 1'b1;
      end else if (do_ovw) begin
        sd_we = 1'b1;
        sd_waddr = match_s;
        sd_wdata = {key[KW-1:0], len, val};
      end else if (do_rm) begin
        fl_we = 1'b1;
        fl_waddr = match_s;
        fl_wdata = 2'b01;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      slot <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          slot <= slot_inc;
          if (slot == AW'(CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= s_axis_tdata[1:0];
            key <= in_key;
            len <= in_len;
            val <= VALUE_WIDTH'(s_axis_tdata[101:70]);
            hash <= '0;
            hidx <= '0;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hidx == len) begin
            slot <= AW'(hash % CAPACITY);
            visited <= '0;
            found <= 1'b0;
            have_tomb <= 1'b0;
            have_empty <= 1'b0;
            state <= S_READ;
          end else begin
            // times 31 as a shift and a subtract
            hash <= 64'(key[8*hidx +: 8]) + (hash << 5) - hash;
            hidx <= hidx + 1'b1;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          priority if (s_tomb) begin
            if (!have_tomb) begin
              have_tomb <= 1'b1;
              tomb_s <= slot;
            end
          end else if (!s_valid) begin
            have_empty <= 1'b1;
            empty_s <= slot;
          end else if (s_match) begin
            found <= 1'b1;
            match_s <= slot;
            match_val <= s_val;
          end
          if ((!s_tomb && (!s_valid || s_match)) || visited == CW'(CAPACITY - 1)) begin
            state <= S_DONE;
          end else begin
            visited <= visited + 1'b1;
            slot <= slot_inc;
            state <= S_READ;
          end
        end
        S_DONE: begin
          vout <= '0;
          if (ins) begin
            if (found) begin
              status <= lpht_pkg::ST_EXISTED;
              vout <= 32'(do_ovw ? val : match_val);
            end else if (have_tomb || have_empty) begin
              status <= lpht_pkg::ST_DONE;
              vout <= 32'(val);
            end else begin
              status <= lpht_pkg::ST_FULL;
            end
          end else if (cmd == lpht_pkg::CMD_GET) begin
            status <= found ? lpht_pkg::ST_EXISTED : lpht_pkg::ST_NOT_FOUND;
            if (found) vout <= 32'(match_val);
          end else begin
            status <= found ? lpht_pkg::ST_DONE : lpht_pkg::ST_NOT_FOUND;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram: generic simple dual port ram
// one write and one read address per cycle, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
